>>> rtl/core/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Used by skt_cell and sorted_key_table_core. No dependencies.
package skt_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 7;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_FULL = 3'd1,
        ST_ZERO = 3'd2,
        ST_DUP  = 3'd3,
        ST_MISS = 3'd4
    } t_status;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_result;

endpackage

>>> rtl/core/skt_cell.sv
// One entry of the sorted key table: holds a key, compares it to the
// broadcast key and shifts to or from its neighbors. Depends on skt_pkg.
module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  t_cell_ctrl          i_ctrl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic                i_prev_lt,
    input  logic [KEY_BITS-1:0] i_next_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_lt,
    output logic                o_eq,
    output logic                o_bnd
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_lt;
    logic                r_eq;
    logic                w_live;

    assign w_live = (32'(i_count) > IDX);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_lt <= w_live && (r_key < i_key);
            r_eq <= w_live && (r_key == i_key);
        end
        if (i_ctrl.ins_en && !r_lt) begin
            r_key <= (o_bnd) ? i_key : i_prev_key;
        end else if (i_ctrl.rem_en && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_bnd = !r_lt && i_prev_lt;

endmodule

>>> rtl/core/sorted_key_table_core.sv
// Top level of the sorted key table: command sequencer, result register
// and a chain of skt_cell entries. Depends on skt_pkg and skt_cell.
//
//   Channel   Direction  Contents (lowest bit first)
//   s_axis    in         cmd[1:0], key[KEY_BITS-1:0], zero pad to bytes
//   m_axis    out        status[2:0], slot[5:0], count[6:0]
//   cfg       in         capacity[6:0], written when i_cfg_we is high
//
// A transaction steps through accept, compare in every cell, decide from
// the reduced compare flags, then shift the cell chain.
// The result is registered and waits for the sink while the next command
// is accepted; the decide step holds only if a previous result is unread.
// Reset clears the count, sets the capacity to 64 and empties the output.
module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // cmd, key, zero pad
    input  logic [((CMD_W+KEY_BITS+7)/8)*8-1:0]         i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // status, slot, count
    output logic [STATUS_W+SLOT_W+CNT_W-1:0]            o_m_axis_tdata,
    input  logic                                        i_cfg_we,
    input  logic [CNT_W-1:0]                            i_cfg_wdata
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_DEC, S_APPLY} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_cap;
    t_result             r_out;
    logic                r_out_valid;
    logic                r_ins;
    logic                r_rem;

    t_cell_ctrl          w_ctrl;
    logic [KEY_BITS-1:0] w_cell_key [DEPTH];
    logic [DEPTH-1:0]    w_lt;
    logic [DEPTH-1:0]    w_eq;
    logic [DEPTH-1:0]    w_bnd;
    logic [IDX_W-1:0]    w_slot_idx;
    logic [SLOT_W-1:0]   w_slot;
    logic                w_found;
    logic                w_full;
    logic                w_fire;
    t_result             w_res;
    logic                w_ins;
    logic                w_rem;

    assign w_ctrl.cmp_en = (r_state == S_CMP);
    assign w_ctrl.ins_en = (r_state == S_APPLY) && r_ins;
    assign w_ctrl.rem_en = (r_state == S_APPLY) && r_rem;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        skt_cell #(
            .IDX      (g),
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_key      (r_key),
            .i_prev_key ((g == 0) ? '0 : w_cell_key[(g == 0) ? 0 : g-1]),
            .i_prev_lt  ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g-1]),
            .i_next_key ((g == DEPTH-1) ? '0 : w_cell_key[(g == DEPTH-1) ? g : g+1]),
            .o_key      (w_cell_key[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g]),
            .o_bnd      (w_bnd[g])
        );
    end

    always_comb begin
        w_slot_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_bnd[i]) begin
                w_slot_idx = w_slot_idx | IDX_W'(i);
            end
        end
    end

    assign w_slot  = SLOT_W'(w_slot_idx);
    assign w_found = |w_eq;
    assign w_full  = (r_count >= r_cap) || (32'(r_count) >= DEPTH);
    assign w_fire  = (r_state == S_DEC) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_res.status = ST_OK;
        w_res.slot   = '0;
        w_res.count  = r_count;
        w_ins        = 1'b0;
        w_rem        = 1'b0;
        case (r_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else if (r_key == '0) begin
                    w_res.status = ST_ZERO;
                end else if (w_found) begin
                    w_res.status = ST_DUP;
                    w_res.slot   = w_slot;
                end else begin
                    w_res.slot  = w_slot;
                    w_res.count = r_count + CNT_W'(1);
                    w_ins       = 1'b1;
                end
            end
            CMD_REMOVE, CMD_LOOKUP: begin
                if (r_key == '0) begin
                    w_res.status = ST_ZERO;
                end else if (w_found) begin
                    w_res.slot = w_slot;
                    if (r_cmd == CMD_REMOVE) begin
                        w_res.count = r_count - CNT_W'(1);
                        w_rem       = 1'b1;
                    end
                end else begin
                    w_res.status = ST_MISS;
                end
            end
            CMD_CLEAR: begin
                w_res.count = '0;
            end
            default: begin
                w_res.count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_axis_tready && !w_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cmd   <= t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
                        r_key   <= i_s_axis_tdata[CMD_W +: KEY_BITS];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (w_fire) begin
                        r_out       <= w_res;
                        r_out_valid <= 1'b1;
                        r_count     <= w_res.count;
                        r_ins       <= w_ins;
                        r_rem       <= w_rem;
                        r_state     <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("Live count exceeds the table depth.");

    a_bnd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> $onehot0(w_bnd))
        else $error("Insert position is not unique.");

    a_eq_at_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> ((w_eq & ~w_bnd) == '0))
        else $error("Matching entry is not at the sorted position.");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Successful insert did not raise the count.");
`endif

endmodule
